>>> rtl/lcg_pkg.sv
package lcg_pkg;

	localparam int VALUE_BITS_DEFAULT = 32;
	localparam int REG_BITS_MAX = 32;
	localparam int RUN_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PC_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 3'd4;

	localparam logic [REG_BITS_MAX-1:0] MULTIPLIER_RESET = 32'd16807;
	localparam logic [REG_BITS_MAX-1:0] INCREMENT_RESET  = 32'd0;
	localparam logic [REG_BITS_MAX-1:0] MODULUS_RESET    = 32'd2147483647;
	localparam logic [REG_BITS_MAX-1:0] SEED_RESET       = 32'd1;
	localparam logic [RUN_W-1:0]        RUN_LENGTH_RESET = 16'd16;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_WAIT   = 4'd0;
	localparam pc_t PC_LOAD_A = 4'd1;
	localparam pc_t PC_RED_A  = 4'd2;
	localparam pc_t PC_LOAD_C = 4'd3;
	localparam pc_t PC_RED_C  = 4'd4;
	localparam pc_t PC_LOAD_X = 4'd5;
	localparam pc_t PC_MUL    = 4'd6;
	localparam pc_t PC_FIN    = 4'd7;
	localparam pc_t PC_EMIT   = 4'd8;

	typedef enum logic [1:0] {
		OPD_MULT,
		OPD_INC,
		OPD_CUR
	} opd_sel_t;

	typedef enum logic {
		ADD_ONE,
		ADD_A
	} add_sel_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_GO,
		JC_LOOP,
		JC_HOLD,
		JC_ALWAYS
	} jump_t;

	typedef struct packed {
		logic     load;
		opd_sel_t opd;
		logic     mac;
		add_sel_t addend;
		logic     save_a;
		logic     save_c;
		logic     fin;
	} dp_ctl_t;

	typedef struct packed {
		logic loop_last;
	} dp_stat_t;

	typedef struct packed {
		dp_ctl_t ctl;
		logic    emit;
		jump_t   jc;
		pc_t     target;
	} ucode_t;

	// reduce a and c mod m by shift-add, then a*x mod m, then add c
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		w = '0;
		unique case (pc)
			PC_WAIT: begin
				w.jc = JC_GO;
				w.target = PC_LOAD_A;
			end
			PC_LOAD_A: begin
				w.ctl.load = 1'b1;
				w.ctl.opd = OPD_MULT;
				w.jc = JC_NEXT;
			end
			PC_RED_A: begin
				w.ctl.mac = 1'b1;
				w.ctl.addend = ADD_ONE;
				w.jc = JC_LOOP;
				w.target = PC_RED_A;
			end
			PC_LOAD_C: begin
				w.ctl.save_a = 1'b1;
				w.ctl.load = 1'b1;
				w.ctl.opd = OPD_INC;
				w.jc = JC_NEXT;
			end
			PC_RED_C: begin
				w.ctl.mac = 1'b1;
				w.ctl.addend = ADD_ONE;
				w.jc = JC_LOOP;
				w.target = PC_RED_C;
			end
			PC_LOAD_X: begin
				w.ctl.save_c = 1'b1;
				w.ctl.load = 1'b1;
				w.ctl.opd = OPD_CUR;
				w.jc = JC_NEXT;
			end
			PC_MUL: begin
				w.ctl.mac = 1'b1;
				w.ctl.addend = ADD_A;
				w.jc = JC_LOOP;
				w.target = PC_MUL;
			end
			PC_FIN: begin
				w.ctl.fin = 1'b1;
				w.jc = JC_NEXT;
			end
			PC_EMIT: begin
				w.emit = 1'b1;
				w.jc = JC_HOLD;
				w.target = PC_WAIT;
			end
			default: begin
				w.jc = JC_ALWAYS;
				w.target = PC_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/lcg_datapath.sv
module lcg_datapath import lcg_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                 clk,
	input  dp_ctl_t              ctl,
	input  logic [(VALUE_BITS < REG_BITS_MAX ? VALUE_BITS : REG_BITS_MAX)-1:0] multiplier,
	input  logic [(VALUE_BITS < REG_BITS_MAX ? VALUE_BITS : REG_BITS_MAX)-1:0] increment,
	input  logic [(VALUE_BITS < REG_BITS_MAX ? VALUE_BITS : REG_BITS_MAX)-1:0] modulus,
	input  logic [VALUE_BITS-1:0] cur,
	output logic [VALUE_BITS-1:0] result,
	output dp_stat_t             stat
);

	localparam int VB = VALUE_BITS;
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VB-1:0]    acc_q;
	logic [VB-1:0]    opd_q;
	logic [VB-1:0]    a_q;
	logic [VB-1:0]    c_q;
	logic [CNT_W-1:0] cnt_q;

	logic [VB-1:0] m_ext;
	logic          mod_zero;
	logic [VB-1:0] addend;
	logic [VB-1:0] dbl;
	logic [VB-1:0] mac_next;
	logic [VB-1:0] fin_val;
	logic [VB-1:0] opd_load;

	// (u + v) mod m for u, v below m; plain wrap when m is zero
	function automatic logic [VB-1:0] add_mod(input logic [VB-1:0] u, input logic [VB-1:0] v,
			input logic [VB-1:0] m, input logic nomod);
		logic [VB:0] s;
		s = {1'b0, u} + {1'b0, v};
		if (!nomod && s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[VB-1:0];
	endfunction

	assign m_ext    = VB'(modulus);
	assign mod_zero = (modulus == '0);

	always_comb begin
		case (ctl.addend)
			ADD_A:   addend = a_q;
			default: addend = VB'(1);
		endcase
	end

	always_comb begin
		case (ctl.opd)
			OPD_MULT: opd_load = VB'(multiplier);
			OPD_INC:  opd_load = VB'(increment);
			OPD_CUR:  opd_load = cur;
			default:  opd_load = '0;
		endcase
	end

	// one bit per cycle, msb first: acc = 2*acc + bit*addend
	assign dbl      = add_mod(acc_q, acc_q, m_ext, mod_zero);
	assign mac_next = opd_q[VB-1] ? add_mod(dbl, addend, m_ext, mod_zero) : dbl;
	assign fin_val  = add_mod(acc_q, c_q, m_ext, mod_zero);

	always_ff @(posedge clk) begin
		if (ctl.save_a) begin
			a_q <= acc_q;
		end
		if (ctl.save_c) begin
			c_q <= acc_q;
		end
		if (ctl.load) begin
			acc_q <= '0;
			opd_q <= opd_load;
			cnt_q <= CNT_W'(VALUE_BITS);
		end else if (ctl.mac) begin
			acc_q <= mac_next;
			opd_q <= {opd_q[VB-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (ctl.fin) begin
			acc_q <= fin_val;
		end
	end

	assign result         = acc_q;
	assign stat.loop_last = (cnt_q == CNT_W'(1));

endmodule

>>> rtl/lcg_sequence_generator.sv
// restart and exhausted steps: result registered in the cycle after the word is accepted
// generating step: no new word is accepted until its result has been emitted;
// the microcode runs the bit-serial modular multiply-add unit three times per
// step
// reset: registers to their defaults, current value to the seed default, step
// count to zero, output empty; no clearing pass
module lcg_sequence_generator import lcg_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_BITS_MAX-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    restart,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [31:0]             value,
	output logic                    kept,
	output logic                    last,
	output logic                    exhausted
);

	localparam int VB = VALUE_BITS;
	localparam int RB = (VALUE_BITS < REG_BITS_MAX) ? VALUE_BITS : REG_BITS_MAX;

	logic [RB-1:0]    mult_q;
	logic [RB-1:0]    inc_q;
	logic [RB-1:0]    mod_q;
	logic [RB-1:0]    seed_q;
	logic [RUN_W-1:0] run_q;

	logic [VB-1:0]    cur_q;
	logic [RUN_W-1:0] steps_q;
	pc_t              pc_q;
	pc_t              pc_next;

	logic             out_valid_q;
	logic [31:0]      value_q;
	logic             kept_q;
	logic             last_q;
	logic             exhausted_q;

	ucode_t           cw;
	dp_stat_t         stat;
	logic [VB-1:0]    result;
	logic             exh;
	logic             out_free;
	logic             in_acc;
	logic             quick;
	logic             go;
	logic             emit_fire;
	logic [RUN_W-1:0] step_inc;

	lcg_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.ctl       (cw.ctl),
		.multiplier(mult_q),
		.increment (inc_q),
		.modulus   (mod_q),
		.cur       (cur_q),
		.result    (result),
		.stat      (stat)
	);

	assign cw        = ucode_rom(pc_q);
	assign exh       = (steps_q >= run_q);
	assign out_free  = !out_valid_q || !out_stall;
	// restart and exhausted words answer without running the program and need the output slot
	assign in_stall  = (cw.jc != JC_GO) || (!out_free && (restart || exh));
	assign in_acc    = in_valid && !in_stall;
	assign quick     = in_acc && (restart || exh);
	assign go        = in_acc && !restart && !exh;
	assign emit_fire = cw.emit && out_free;
	assign step_inc  = steps_q + RUN_W'(1);

	always_comb begin
		case (cw.jc)
			JC_NEXT:   pc_next = pc_q + pc_t'(1);
			JC_GO:     pc_next = go ? cw.target : pc_q;
			JC_LOOP:   pc_next = stat.loop_last ? pc_q + pc_t'(1) : cw.target;
			JC_HOLD:   pc_next = out_free ? cw.target : pc_q;
			JC_ALWAYS: pc_next = cw.target;
			default:   pc_next = PC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= RB'(MULTIPLIER_RESET);
			inc_q  <= RB'(INCREMENT_RESET);
			mod_q  <= RB'(MODULUS_RESET);
			seed_q <= RB'(SEED_RESET);
			run_q  <= RUN_LENGTH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MULTIPLIER: mult_q <= RB'(cfg_data);
				REG_INCREMENT:  inc_q  <= RB'(cfg_data);
				REG_MODULUS:    mod_q  <= RB'(cfg_data);
				REG_SEED:       seed_q <= RB'(cfg_data);
				REG_RUN_LENGTH: run_q  <= cfg_data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_WAIT;
			cur_q       <= VB'(RB'(SEED_RESET));
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (quick) begin
				out_valid_q <= 1'b1;
				if (restart) begin
					cur_q   <= VB'(seed_q);
					steps_q <= '0;
				end
			end else if (emit_fire) begin
				out_valid_q <= 1'b1;
				cur_q       <= result;
				steps_q     <= step_inc;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (quick) begin
			value_q     <= '0;
			kept_q      <= 1'b0;
			last_q      <= 1'b0;
			exhausted_q <= !restart;
		end else if (emit_fire) begin
			value_q     <= 32'(result);
			kept_q      <= (result != VB'(seed_q));
			last_q      <= (step_inc == run_q);
			exhausted_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign kept      = kept_q;
	assign last      = last_q;
	assign exhausted = exhausted_q;

	a_go_starts_program: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> pc_q == PC_LOAD_A)
		else $error("accepted step did not start the program");

	a_emit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> out_valid && !exhausted && steps_q == $past(steps_q) + RUN_W'(1))
		else $error("generated word not presented or step count off");

	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exhausted |-> value == '0 && !kept && !last)
		else $error("exhausted word carries data");

	a_restart_reload: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && restart |=> steps_q == '0 && cur_q == VB'($past(seed_q)) && out_valid)
		else $error("restart did not reload the seed");

endmodule
